FILE: design/adf_pkg.sv
// ----------------------------------------------------------------------------
// adf_pkg
// Shared types, character codes and the power-of-ten table for the ASCII
// decimal to fixed-point converter.
// ----------------------------------------------------------------------------
package adf_pkg;

    localparam int unsigned INT_W  = 31;
    localparam int unsigned FRAC_W = 30;
    localparam int unsigned CNT_W  = 4;

    localparam logic [INT_W-1:0] INT_MAX = {INT_W{1'b1}};

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_COMMA = 8'd44;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_POINT = 8'd46;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_INT,
        PH_FRAC,
        PH_STOP
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_LOAD
    } t_state;

    typedef struct packed {
        logic take;
        logic step;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic is_nul;
        logic div_done;
        logic out_free;
    } t_status;

    function automatic logic [FRAC_W-1:0] pow10(input logic [CNT_W-1:0] idx);
        logic [FRAC_W-1:0] p;
        unique case (idx)
            4'd0:    p = 30'd1;
            4'd1:    p = 30'd10;
            4'd2:    p = 30'd100;
            4'd3:    p = 30'd1000;
            4'd4:    p = 30'd10000;
            4'd5:    p = 30'd100000;
            4'd6:    p = 30'd1000000;
            4'd7:    p = 30'd10000000;
            4'd8:    p = 30'd100000000;
            4'd9:    p = 30'd1000000000;
            default: p = 30'd1000000000;
        endcase
        return p;
    endfunction

endpackage

FILE: design/adf_ctrl.sv
// ----------------------------------------------------------------------------
// adf_ctrl
// Sequencer: takes characters, runs the fraction divide after a NUL and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module adf_ctrl
    import adf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_status.is_nul) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_status.div_done) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid;
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
            end
            ST_LOAD: begin
                o_cmd.load = i_status.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

FILE: design/adf_dp.sv
// ----------------------------------------------------------------------------
// adf_dp
// Datapath: character parser, restoring fraction divider and output register.
// ----------------------------------------------------------------------------
module adf_dp
    import adf_pkg::*;
#(
    parameter int unsigned FRAC_BITS       = 32,
    parameter int unsigned MAX_FRAC_DIGITS = 9
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [7:0]  i_char,
    input  logic        i_out_ready,
    output t_status     o_status,
    output logic        o_out_valid,
    output logic [63:0] o_value,
    output logic        o_overflow
);

    localparam int unsigned MAG_W = INT_W + FRAC_BITS;
    localparam int unsigned DC_W  = $clog2(FRAC_BITS);
    localparam logic [DC_W-1:0]  DC_LAST  = DC_W'(FRAC_BITS - 1);
    localparam logic [CNT_W-1:0] MAX_DIGS = CNT_W'(MAX_FRAC_DIGITS);

    t_phase            r_phase;
    t_phase            n_phase;
    logic              r_neg;
    logic              r_seen;
    logic              r_sat;
    logic [INT_W-1:0]  r_int;
    logic [FRAC_W-1:0] r_fv;
    logic [CNT_W-1:0]  r_cnt;

    logic [FRAC_W-1:0]    r_rem;
    logic [FRAC_W-1:0]    r_div;
    logic [FRAC_BITS-1:0] r_q;
    logic [DC_W-1:0]      r_dc;

    logic        r_out_valid;
    logic [63:0] r_value;
    logic        r_ovf;

    logic             is_digit;
    logic             is_space;
    logic [3:0]       digit;
    logic [34:0]      int_next;
    logic [FRAC_W:0]  rem2;
    logic [FRAC_W:0]  trial;
    logic [63:0]      mag;

    assign is_digit = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign is_space = ((i_char >= CH_TAB) && (i_char <= CH_CR)) || (i_char == CH_SPACE);
    assign digit    = 4'(i_char - CH_ZERO);
    assign int_next = ({4'd0, r_int} << 3) + ({4'd0, r_int} << 1) + {31'd0, digit};
    assign rem2     = {r_rem, 1'b0};
    assign trial    = rem2 - {1'b0, r_div};
    assign mag      = {{(64 - MAG_W){1'b0}}, r_int, r_q};

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_SKIP: begin
                if (is_space) begin
                    n_phase = PH_SKIP;
                end else if (is_digit || i_char == CH_PLUS || i_char == CH_MINUS) begin
                    n_phase = PH_INT;
                end else begin
                    n_phase = PH_STOP;
                end
            end
            PH_INT: begin
                if (is_digit) begin
                    n_phase = PH_INT;
                end else if ((i_char == CH_POINT || i_char == CH_COMMA) && r_seen) begin
                    n_phase = PH_FRAC;
                end else begin
                    n_phase = PH_STOP;
                end
            end
            PH_FRAC: begin
                if (!is_digit) begin
                    n_phase = PH_STOP;
                end
            end
            PH_STOP: n_phase = PH_STOP;
            default: n_phase = PH_STOP;
        endcase
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load) begin
            r_phase <= PH_SKIP;
            r_neg   <= 1'b0;
            r_seen  <= 1'b0;
            r_sat   <= 1'b0;
            r_int   <= '0;
            r_fv    <= '0;
            r_cnt   <= '0;
        end else if (i_cmd.take && i_char != CH_NUL) begin
            r_phase <= n_phase;
            if (r_phase == PH_SKIP && i_char == CH_MINUS) begin
                r_neg <= 1'b1;
            end
            if (is_digit && (r_phase == PH_SKIP || r_phase == PH_INT)) begin
                r_seen <= 1'b1;
                if (!r_sat) begin
                    if (int_next > {4'd0, INT_MAX}) begin
                        r_int <= INT_MAX;
                        r_sat <= 1'b1;
                    end else begin
                        r_int <= int_next[INT_W-1:0];
                    end
                end
            end
            if (is_digit && r_phase == PH_FRAC && r_cnt < MAX_DIGS) begin
                r_fv  <= FRAC_W'(({4'd0, r_fv} << 3) + ({4'd0, r_fv} << 1) + {30'd0, digit});
                r_cnt <= r_cnt + 4'd1;
            end
        end
    end

    // restoring divide: (fv << FRAC_BITS) / 10^cnt, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && i_char == CH_NUL) begin
            r_rem <= r_fv;
            r_div <= pow10(r_cnt);
            r_q   <= '0;
            r_dc  <= '0;
        end else if (i_cmd.step) begin
            r_dc <= r_dc + 1'b1;
            if (!trial[FRAC_W]) begin
                r_rem <= trial[FRAC_W-1:0];
                r_q   <= {r_q[FRAC_BITS-2:0], 1'b1};
            end else begin
                r_rem <= rem2[FRAC_W-1:0];
                r_q   <= {r_q[FRAC_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= r_neg ? (64'd0 - mag) : mag;
            r_ovf   <= r_sat;
        end
    end

    assign o_status.is_nul   = (i_char == CH_NUL);
    assign o_status.div_done = (r_dc == DC_LAST);
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_value           = r_value;
    assign o_overflow        = r_ovf;

`ifndef SYNTHESIS
    a_sat_holds_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sat |-> (r_int == INT_MAX))
        else $error("saturated accumulator not at maximum");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= MAX_DIGS)
        else $error("fraction digit count past limit");
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_rem < r_div))
        else $error("divider remainder not below divisor");
    a_load_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (r_out_valid && r_ovf == $past(r_sat)))
        else $error("output register not loaded");
`endif

endmodule

FILE: design/ascii_decimal_to_fixed_point.sv
// ----------------------------------------------------------------------------
// ascii_decimal_to_fixed_point
// Parses an ASCII decimal string, one character per word, into signed
// Q31.FRAC_BITS fixed point with truncation and integer saturation.
//
//   channel  dir  tdata              tuser
//   s_axis   in   [7:0] char_code    -
//   m_axis   out  [63:0] value       [0] overflow
//
// A non-NUL character is taken whenever the sequencer is idle.
// A NUL is handled in order: accept, FRAC_BITS steps of the one-bit
// restoring divider for the fraction, and a load into the output register.
// The load waits while the output register holds an untaken word; the input
// is held off from the NUL until the load.
// Reset is synchronous and clears parser, sequencer and output valid.
// ----------------------------------------------------------------------------
module ascii_decimal_to_fixed_point
    import adf_pkg::*;
#(
    parameter int unsigned FRAC_BITS       = 32,
    parameter int unsigned MAX_FRAC_DIGITS = 9
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [63:0] value
    output logic        m_axis_tuser    // [0] overflow
);

    t_cmd    cmd;
    t_status status;

    adf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_status   (status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    adf_dp #(
        .FRAC_BITS       (FRAC_BITS),
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_char      (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_status    (status),
        .o_out_valid (m_axis_tvalid),
        .o_value     (m_axis_tdata),
        .o_overflow  (m_axis_tuser)
    );

endmodule
